@@ sv/tvs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tvs_pkg;

   // Field widths
   localparam int SOIL_W   = 18;
   localparam int HEIGHT_W = 20;
   localparam int DEPTH_W  = 16;
   localparam int CHAN_W   = 8;
   localparam int NUM_CH   = 3;
   localparam int SPAN_W   = 16;  // position within one height segment, 0..40960
   localparam int ALPHA_W  = 14;  // alpha scaled by 9216
   localparam int PROD_W   = 23;  // slope times span
   localparam int QUOT_W   = 11;  // product over 4096
   localparam int RECIP_W  = 25;  // quotient times reciprocal of ten
   localparam int MIX_W    = 22;  // blend numerator
   localparam int SCALE_W  = 12;  // blend numerator over 1024
   localparam int NINTH_W  = 24;  // scaled times reciprocal of nine

   // Thresholds
   localparam logic [SOIL_W-1:0]   ROCK_LIMIT = 18'd20;
   localparam logic [HEIGHT_W-1:0] H_LOW      = 20'd40960;
   localparam logic [HEIGHT_W-1:0] H_SEG      = 20'd40960;
   localparam logic [HEIGHT_W-1:0] H_TOP      = 20'd81920;
   localparam logic [SPAN_W-1:0]   SPAN_FULL  = 16'd40960;
   localparam logic [DEPTH_W-1:0]  A_KNEE     = 16'd204;
   localparam logic [DEPTH_W-1:0]  A_FULL     = 16'd2048;
   localparam logic [ALPHA_W-1:0]  A_ONE      = 14'd9216;
   localparam logic [ALPHA_W-1:0]  A_RAMP     = 14'd27;
   localparam logic [12:0]         A_OFFSET   = 13'd2560;

   // Division helpers: ceiling bias for 40960, reciprocals of ten and nine
   localparam logic [PROD_W-1:0]  SEG_BIAS   = 23'd40959;
   localparam logic [RECIP_W-1:0] RECIP_TEN  = 25'd6554;
   localparam logic [NINTH_W-1:0] RECIP_NINE = 24'd7282;

   // Colour tables, indexed [segment][channel] with red, green, blue in order
   localparam logic [CHAN_W-1:0] SEG_BASE [2][NUM_CH] = '{
      '{8'd60,  8'd120, 8'd60},
      '{8'd110, 8'd95,  8'd50}
   };
   localparam logic [CHAN_W-1:0] SEG_SLOPE [2][NUM_CH] = '{
      '{8'd50, 8'd25, 8'd10},
      '{8'd70, 8'd85, 8'd130}
   };
   localparam logic SEG_DOWN [2][NUM_CH] = '{
      '{1'b0, 1'b1, 1'b1},
      '{1'b0, 1'b0, 1'b0}
   };
   localparam logic [CHAN_W-1:0] ROCK_RGB  [NUM_CH] = '{8'd135, 8'd125, 8'd125};
   localparam logic [CHAN_W-1:0] WATER_RGB [NUM_CH] = '{8'd30,  8'd90,  8'd220};

   // Classified cell, handed from front to back
   typedef struct packed {
      logic               rock;
      logic               upper;
      logic [SPAN_W-1:0]  span;
      logic [ALPHA_W-1:0] alpha;
   } cls_type;

   typedef struct packed {
      logic                         rock;
      logic                         upper;
      logic [ALPHA_W-1:0]           alpha;
      logic [NUM_CH-1:0][PROD_W-1:0] prod;
   } prod_stage_type;

   typedef struct packed {
      logic [ALPHA_W-1:0]            alpha;
      logic [NUM_CH-1:0][CHAN_W-1:0] land;
   } land_stage_type;

   typedef struct packed {
      logic [NUM_CH-1:0][SCALE_W-1:0] scaled;
   } mix_stage_type;

   typedef struct packed {
      logic [NUM_CH-1:0][CHAN_W-1:0] rgb;
   } pix_stage_type;

   // Status seen by the top level
   typedef struct packed {
      logic       front_valid;
      logic [1:0] queue_fill;
   } status_type;

endpackage

`default_nettype wire

@@ sv/tvs_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface tvs_req_if;
   logic                          valid;
   logic                          ready;
   logic [tvs_pkg::SOIL_W-1:0]    soil_thickness;
   logic [tvs_pkg::HEIGHT_W-1:0]  surface_height;
   logic [tvs_pkg::DEPTH_W-1:0]   flood_depth;

   modport source (output valid, soil_thickness, surface_height, flood_depth, input ready);
   modport sink   (input valid, soil_thickness, surface_height, flood_depth, output ready);
endinterface

interface tvs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tvs_pkg::CHAN_W-1:0]  red;
   logic [tvs_pkg::CHAN_W-1:0]  green;
   logic [tvs_pkg::CHAN_W-1:0]  blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

@@ sv/tvs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tvs_front (
   input  wire logic         clock,
   input  wire logic         reset,
   tvs_req_if.sink           req_bus,
   output logic              push_valid,
   output tvs_pkg::cls_type  push_data,
   input  wire logic         push_ready
);

   logic             valid_ff;
   logic             valid_in;
   tvs_pkg::cls_type data_ff;
   tvs_pkg::cls_type data_in;
   logic [tvs_pkg::HEIGHT_W-1:0] rise;
   logic                         take;

   assign req_bus.ready = !valid_ff || push_ready;
   assign take          = req_bus.valid && req_bus.ready;
   assign push_valid    = valid_ff;
   assign push_data     = data_ff;

   // Classify: rock test, height segment and alpha
   always_comb begin
      rise = (req_bus.surface_height > tvs_pkg::H_LOW) ?
             req_bus.surface_height - tvs_pkg::H_LOW : '0;
      data_in.rock = req_bus.soil_thickness <= tvs_pkg::ROCK_LIMIT;
      if (rise >= tvs_pkg::H_TOP) begin
         data_in.upper = 1'b1;
         data_in.span  = tvs_pkg::SPAN_FULL;
      end else if (rise >= tvs_pkg::H_SEG) begin
         data_in.upper = 1'b1;
         data_in.span  = tvs_pkg::SPAN_W'(rise - tvs_pkg::H_SEG);
      end else begin
         data_in.upper = 1'b0;
         data_in.span  = tvs_pkg::SPAN_W'(rise);
      end
      if (req_bus.flood_depth <= tvs_pkg::A_KNEE) begin
         data_in.alpha = tvs_pkg::ALPHA_W'(req_bus.flood_depth[7:0]) * tvs_pkg::A_RAMP;
      end else if (req_bus.flood_depth < tvs_pkg::A_FULL) begin
         data_in.alpha = {13'(req_bus.flood_depth[10:0]) + tvs_pkg::A_OFFSET, 1'b0};
      end else begin
         data_in.alpha = tvs_pkg::A_ONE;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/tvs_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tvs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire tvs_pkg::cls_type  in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output tvs_pkg::cls_type       out_data,
   input  wire logic              out_ready,
   output logic [1:0]             fill
);

   tvs_pkg::cls_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign fill      = count_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

@@ sv/tvs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tvs_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   input  wire tvs_pkg::cls_type  pop_data,
   output logic                   pop_ready,
   tvs_rsp_if.source              rsp_bus
);

   tvs_pkg::prod_stage_type prod_ff, prod_in;
   tvs_pkg::land_stage_type land_ff, land_in;
   tvs_pkg::mix_stage_type  mix_ff,  mix_in;
   tvs_pkg::pix_stage_type  pix_ff,  pix_in;
   logic [3:0] valid_ff, valid_in;
   logic [3:0] adv;

   logic [tvs_pkg::PROD_W-1:0]  biased [tvs_pkg::NUM_CH];
   logic [tvs_pkg::RECIP_W-1:0] tenth  [tvs_pkg::NUM_CH];
   logic [tvs_pkg::CHAN_W-1:0]  step   [tvs_pkg::NUM_CH];
   logic [tvs_pkg::MIX_W-1:0]   mix    [tvs_pkg::NUM_CH];
   logic [tvs_pkg::NINTH_W-1:0] ninth  [tvs_pkg::NUM_CH];
   logic                        down   [tvs_pkg::NUM_CH];

   // Advance a stage when it is empty or the next one advances
   assign adv[3] = !valid_ff[3] || rsp_bus.ready;
   assign adv[2] = !valid_ff[2] || adv[3];
   assign adv[1] = !valid_ff[1] || adv[2];
   assign adv[0] = !valid_ff[0] || adv[1];
   assign pop_ready = adv[0];

   assign rsp_bus.valid = valid_ff[3];
   assign rsp_bus.red   = pix_ff.rgb[0];
   assign rsp_bus.green = pix_ff.rgb[1];
   assign rsp_bus.blue  = pix_ff.rgb[2];

   always_comb begin
      prod_in.rock  = pop_data.rock;
      prod_in.upper = pop_data.upper;
      prod_in.alpha = pop_data.alpha;
      for (int i = 0; i < tvs_pkg::NUM_CH; i++) begin
         prod_in.prod[i] = tvs_pkg::PROD_W'(tvs_pkg::SEG_SLOPE[pop_data.upper][i]) *
                           tvs_pkg::PROD_W'(pop_data.span);
      end
   end

   // Falling channels round the step up so that base minus step floors
   always_comb begin
      land_in.alpha = prod_ff.alpha;
      for (int i = 0; i < tvs_pkg::NUM_CH; i++) begin
         down[i]   = tvs_pkg::SEG_DOWN[prod_ff.upper][i];
         biased[i] = prod_ff.prod[i] + (down[i] ? tvs_pkg::SEG_BIAS : '0);
         tenth[i]  = tvs_pkg::RECIP_W'(biased[i][tvs_pkg::PROD_W-1:12]) * tvs_pkg::RECIP_TEN;
         step[i]   = tenth[i][23:16];
         if (prod_ff.rock) begin
            land_in.land[i] = tvs_pkg::ROCK_RGB[i];
         end else if (down[i]) begin
            land_in.land[i] = tvs_pkg::SEG_BASE[prod_ff.upper][i] - step[i];
         end else begin
            land_in.land[i] = tvs_pkg::SEG_BASE[prod_ff.upper][i] + step[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < tvs_pkg::NUM_CH; i++) begin
         mix[i] = tvs_pkg::MIX_W'(tvs_pkg::A_ONE - land_ff.alpha) *
                  tvs_pkg::MIX_W'(land_ff.land[i]) +
                  tvs_pkg::MIX_W'(land_ff.alpha) * tvs_pkg::MIX_W'(tvs_pkg::WATER_RGB[i]);
         mix_in.scaled[i] = mix[i][tvs_pkg::MIX_W-1:10];
      end
   end

   // Finish the division by 9216 with a reciprocal of nine
   always_comb begin
      for (int i = 0; i < tvs_pkg::NUM_CH; i++) begin
         ninth[i]      = tvs_pkg::NINTH_W'(mix_ff.scaled[i]) * tvs_pkg::RECIP_NINE;
         pix_in.rgb[i] = ninth[i][23:16];
      end
   end

   always_comb begin
      valid_in[0] = adv[0] ? pop_valid   : valid_ff[0];
      valid_in[1] = adv[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = adv[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = adv[3] ? valid_ff[2] : valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         prod_ff <= prod_in;
      end
      if (adv[1]) begin
         land_ff <= land_in;
      end
      if (adv[2]) begin
         mix_ff <= mix_in;
      end
      if (adv[3]) begin
         pix_ff <= pix_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/terrain_top_view_shade.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Top-down terrain shader: one RGB pixel for each map cell.
// req_bus carries a cell (soil_thickness, surface_height, flood_depth, all
// unsigned in 1/4096 m); rsp_bus returns red, green and blue, 8 bits each.
// Both channels move a transaction on a rising edge with valid and ready high.
// Exactly one response leaves for every request, in request order.
// A response is first offered once its request has passed the front register,
// the queue and the back pipeline registers. Throughput: one cell per clock, held
// for as long as the receiver keeps ready high.
// The front register classifies the cell (rock test, height segment, water
// alpha) and feeds a two-entry queue; the back pipeline runs three arithmetic
// stages and an output register.
// When the receiver stalls, the back pipeline fills first, then the queue,
// then the front register, and only then does req_bus.ready drop.
// Synchronous reset empties the front register, queue and pipeline; no
// response is pending after it. There is no configuration.

module terrain_top_view_shade (
   input  wire logic  clock,
   input  wire logic  reset,
   tvs_req_if.sink    req_bus,
   tvs_rsp_if.source  rsp_bus
);

   logic                 push_valid;
   logic                 push_ready;
   tvs_pkg::cls_type     push_data;
   logic                 pop_valid;
   logic                 pop_ready;
   tvs_pkg::cls_type     pop_data;
   tvs_pkg::status_type  status;

   // Front: accept and classify
   tvs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   // Decouple front and back so each can stall on its own
   tvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_data   (push_data),
      .in_ready  (push_ready),
      .out_valid (pop_valid),
      .out_data  (pop_data),
      .out_ready (pop_ready),
      .fill      (status.queue_fill)
   );

   assign status.front_valid = push_valid;

   // Back: land colour, water blend, output register
   tvs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   // The queue never claims more than its two slots
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      status.queue_fill != 2'd3)
      else $error("queue fill exceeds capacity");

   // A taken request always lands in the front register
   a_front_load: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> status.front_valid)
      else $error("accepted transaction lost at front");

   // A stalled front item stays put until the queue takes it
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      (status.front_valid && status.queue_fill == 2'd2 && !pop_ready)
      |=> status.front_valid && $stable(push_data))
      else $error("front transaction dropped while queue full");

   // Reset leaves nothing in flight
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid && !status.front_valid && status.queue_fill == 2'd0)
      else $error("transaction pending after reset");
`endif

endmodule

`default_nettype wire
